### rtl/kstm_pkg.sv
`timescale 1ns / 1ps
// Package for the key sequence trie matcher: sizes, operation codes,
// payload structs, node row layout and the node store request bundle.
package kstm_pkg;

  localparam int NumKeys  = 8;
  localparam int NumNodes = 256;
  // Node capacity; always room for the root and one child per key.
  localparam int Capacity = (NumNodes > NumKeys) ? NumNodes : NumKeys + 1;
  localparam int NodeW    = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KeyIdxW  = $clog2(NumKeys);

  localparam int ApbAddrW = 3;
  localparam logic RegThreshold = 1'b0;  // word index of timeout_threshold

  localparam logic [1:0] OpPress    = 2'd0;
  localparam logic [1:0] OpTick     = 2'd1;
  localparam logic [1:0] OpRegister = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  key;
    logic [15:0] elapsed;
    logic        seq_start;
    logic        seq_end;
    logic [7:0]  task_id;
  } item_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_task;
    logic       timed_out;
    logic       table_full;
  } result_t;

  // One node: child link per key (0 = no child) and its task id.
  typedef struct packed {
    logic [NumKeys-1:0][NodeW-1:0] link;
    logic [7:0]                    task_id;
  } node_row_t;

  typedef struct packed {
    logic             rd_en;
    logic [NodeW-1:0] rd_addr;
    logic             wr_en;
    logic [NodeW-1:0] wr_addr;
    node_row_t        wr_row;
  } mem_req_t;

  // Reset contents of the root row: key k links to node k+1.
  function automatic node_row_t root_row();
    node_row_t r;
    r = '0;
    for (int k = 0; k < NumKeys; k++) begin
      r.link[k] = NodeW'(k + 1);
    end
    return r;
  endfunction

endpackage

### rtl/kstm_node_store.sv
`timescale 1ns / 1ps
// Node table of the trie matcher: one row per node in a synchronous RAM,
// per-row valid flops standing in for the reset contents. Uses kstm_pkg.
module kstm_node_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kstm_pkg::mem_req_t  req_i,
  output kstm_pkg::node_row_t rd_row_o
);
  import kstm_pkg::*;

  node_row_t               mem_q [Capacity];
  node_row_t               rd_data_q;
  logic [Capacity-1:0]     row_valid_q;
  logic                    rd_valid_q;
  logic                    rd_root_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_row;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      rd_root_q   <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_addr];
        rd_root_q  <= (req_i.rd_addr == '0);
      end
    end
  end

  // Unwritten rows read as their reset value.
  assign rd_row_o = rd_valid_q ? rd_data_q : (rd_root_q ? root_row() : '0);

endmodule

### rtl/key_sequence_trie_matcher.sv
`timescale 1ns / 1ps
// Top level of the key sequence trie matcher: command port, APB register,
// control sequencer. Depends on kstm_pkg and kstm_node_store.
//
// Usage:
//  - Items enter on item_i; a beat is taken at a clock edge with start high
//    and busy low. Each item yields exactly one result beat on result_o,
//    marked by done_o for one cycle; the receiver cannot stall it.
//  - Tick items and no-op items (unused operation) finish in the accept
//    cycle: done_o follows in the next cycle, busy stays low, so one per cycle.
//  - Key presses take two dependent node-table reads (child link, then the
//    child's task): busy through S_PRESS_LINK and S_PRESS_TASK, done_o
//    registered at the end. A miss ends after the first read.
//  - Register items read the walk node, then write it back with a new
//    link (at seq_end also writing a fresh child row with the task),
//    read/write an existing child to attach the task, or follow the link.
//  - One node-RAM access per step; reads return from a registered RAM port.
//  - Reset: the trie holds only the root and its one child per key, all
//    tasks zero, cursors at root, accumulator zero, threshold zero. No
//    clearing pass: per-row valid flops supply the reset contents.
//  - timeout_threshold sits at APB address 0; write it only while idle.
module key_sequence_trie_matcher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  kstm_pkg::item_t       item_i,
  // result channel
  output logic                  done_o,
  output kstm_pkg::result_t     result_o,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [kstm_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import kstm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRESS_LINK,  // cursor row arrives, follow child link
    S_PRESS_TASK,  // child row arrives, check task
    S_REG_LINK,    // walk row arrives, allocate or follow
    S_REG_TASK,    // existing child row arrives, attach task
    S_REG_NEW      // write fresh child row holding the task
  } state_e;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [NodeW-1:0] match_cur_q, match_cur_d;
  logic [NodeW-1:0] reg_cur_q, reg_cur_d;
  logic [CntW-1:0]  nodes_used_q, nodes_used_d;
  logic [31:0]      time_accum_q, time_accum_d;
  logic [31:0]      threshold_q, threshold_d;
  logic             done_q, done_d;
  result_t          result_q, result_d;

  mem_req_t         mem_req;
  node_row_t        rd_row;
  node_row_t        row_mod;
  logic [NodeW-1:0] link;
  logic [KeyIdxW-1:0] key_idx;
  logic             key_in_ok;
  logic [32:0]      tick_sum;
  logic [31:0]      tick_sat;
  logic             cfg_wr;

  kstm_node_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_row_o (rd_row)
  );

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // APB: single register, zero-wait
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegThreshold);
  assign prdata = (paddr[2] == RegThreshold) ? threshold_q : '0;

  assign key_in_ok  = (32'(item_i.key) < NumKeys);
  assign key_idx    = KeyIdxW'(item_q.key);
  assign link       = rd_row.link[key_idx];

  // saturating accumulate for ticks
  assign tick_sum = {1'b0, time_accum_q} + 33'(item_i.elapsed);
  assign tick_sat = tick_sum[32] ? '1 : tick_sum[31:0];

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    node_d       = node_q;
    match_cur_d  = match_cur_q;
    reg_cur_d    = reg_cur_q;
    nodes_used_d = nodes_used_q;
    time_accum_d = time_accum_q;
    threshold_d  = cfg_wr ? pwdata : threshold_q;
    done_d       = 1'b0;
    result_d     = '0;
    mem_req      = '0;
    row_mod      = rd_row;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = item_i;
          case (item_i.operation)
            OpPress: begin
              if (key_in_ok) begin
                time_accum_d    = '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = match_cur_q;
                state_d         = S_PRESS_LINK;
              end else begin
                done_d = 1'b1;
              end
            end
            OpTick: begin
              done_d = 1'b1;
              if (tick_sat > threshold_q) begin
                match_cur_d        = '0;
                time_accum_d       = '0;
                result_d.timed_out = 1'b1;
              end else begin
                time_accum_d = tick_sat;
              end
            end
            OpRegister: begin
              if (key_in_ok) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = item_i.seq_start ? '0 : reg_cur_q;
                node_d          = item_i.seq_start ? '0 : reg_cur_q;
                state_d         = S_REG_LINK;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_PRESS_LINK: begin
        if (link == '0) begin
          // miss: restart from the root's child, its task is not checked
          match_cur_d = NodeW'(32'(item_q.key) + 1);
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = link;
          node_d          = link;
          state_d         = S_PRESS_TASK;
        end
      end

      S_PRESS_TASK: begin
        if (rd_row.task_id != '0) begin
          result_d.fired      = 1'b1;
          result_d.fired_task = rd_row.task_id;
          match_cur_d         = '0;
        end else begin
          match_cur_d = node_q;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_REG_LINK: begin
        state_d = S_IDLE;
        if (link == '0) begin
          if (nodes_used_q < CntW'(Capacity)) begin
            row_mod.link[key_idx] = nodes_used_q[NodeW-1:0];
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = node_q;
            mem_req.wr_row  = row_mod;
            nodes_used_d    = nodes_used_q + 1'b1;
            if (item_q.seq_end) begin
              node_d  = nodes_used_q[NodeW-1:0];
              state_d = S_REG_NEW;
            end else begin
              reg_cur_d = nodes_used_q[NodeW-1:0];
              done_d    = 1'b1;
            end
          end else begin
            result_d.table_full = 1'b1;
            done_d              = 1'b1;
          end
        end else if (item_q.seq_end) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = link;
          node_d          = link;
          state_d         = S_REG_TASK;
        end else begin
          reg_cur_d = link;
          done_d    = 1'b1;
        end
      end

      S_REG_TASK: begin
        row_mod.task_id = item_q.task_id;
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = node_q;
        mem_req.wr_row  = row_mod;
        reg_cur_d       = '0;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      S_REG_NEW: begin
        mem_req.wr_en          = 1'b1;
        mem_req.wr_addr        = node_q;
        mem_req.wr_row         = '0;
        mem_req.wr_row.task_id = item_q.task_id;
        reg_cur_d              = '0;
        done_d                 = 1'b1;
        state_d                = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      node_q       <= '0;
      match_cur_q  <= '0;
      reg_cur_q    <= '0;
      nodes_used_q <= CntW'(NumKeys + 1);
      time_accum_q <= '0;
      threshold_q  <= '0;
      done_q       <= 1'b0;
      result_q     <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      node_q       <= node_d;
      match_cur_q  <= match_cur_d;
      reg_cur_q    <= reg_cur_d;
      nodes_used_q <= nodes_used_d;
      time_accum_q <= time_accum_d;
      threshold_q  <= threshold_d;
      done_q       <= done_d;
      result_q     <= result_d;
    end
  end

  // node allocation never runs past the table
  a_nodes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= CntW'(Capacity))
    else $error("node count beyond capacity");

  // cursors only ever point at allocated nodes
  a_cursor_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(match_cur_q) < nodes_used_q) && (CntW'(reg_cur_q) < nodes_used_q))
    else $error("cursor points at unallocated node");

  // at most one outcome per result beat, and a fire carries a task
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($countones({result_q.fired, result_q.timed_out,
                            result_q.table_full}) <= 1) &&
               (result_q.fired == (result_q.fired_task != '0)))
    else $error("malformed result beat");

  // table writes happen only in the registration states
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (state_q == S_REG_LINK || state_q == S_REG_TASK ||
                       state_q == S_REG_NEW))
    else $error("node table written outside registration");

  // a busy item always finishes with a beat when returning to idle
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_q)
    else $error("item left without result beat");

endmodule

### dv/tb_key_sequence_trie_matcher.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_sequence_trie_matcher: directed and random beats
// are scored against an in-bench trie predictor. Depends on kstm_pkg and the RTL only.
module tb_key_sequence_trie_matcher;
  import kstm_pkg::*;

  // Operation code that the block leaves unused; it must answer with an all-zero result.
  localparam logic [1:0] OpNone = 2'd3;
  localparam logic [ApbAddrW-1:0] ThresholdAddr = ApbAddrW'(4 * int'(RegThreshold));
  // Watchdog limit, many times the slowest beat plus the longest sender gap.
  localparam int StallLimit = 2000;
  localparam int MaxReports = 30;

  // Stored combinations for replay: up to 4 keys, in the order they are pressed.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][2:0] keys;
  } combo_t;

  logic                clk_i;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  item_t               item_i  = '0;
  logic                done_o;
  result_t             result_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  key_sequence_trie_matcher uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Trie predictor: its own copy of the node table, cursors, time accumulator
  // and threshold. Advanced once per accepted beat, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [NodeW-1:0] link_tab [Capacity][NumKeys];
  logic [7:0]       task_tab [Capacity];
  int unsigned      used_nodes;
  logic [NodeW-1:0] match_node;
  logic [NodeW-1:0] walk_node;
  logic [31:0]      elapsed_sum;
  logic [31:0]      threshold;

  result_t          pending_results [$];   // expected result beats, oldest first
  combo_t           combos [$];            // registered combinations for replay
  int unsigned      sent_count;            // beats that do real work
  int unsigned      burst_left;
  bit               idle_on;
  int               error_count;
  int               stall_cycles;
  result_t          want;

  function automatic void trie_clear();
    for (int n = 0; n < Capacity; n++) begin
      task_tab[n] = '0;
      for (int k = 0; k < NumKeys; k++) begin
        link_tab[n][k] = (n == 0) ? NodeW'(k + 1) : '0;
      end
    end
    used_nodes  = NumKeys + 1;
    match_node  = '0;
    walk_node   = '0;
    elapsed_sum = '0;
    threshold   = '0;
  endfunction

  function automatic result_t trie_step(item_t it);
    result_t          r;
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] child;
    logic [32:0]      sum;
    r = '0;
    if (it.operation == OpPress && it.key < NumKeys) begin
      child       = link_tab[match_node][it.key];
      elapsed_sum = '0;
      if (child == '0) begin
        // miss: restart from the root's child for this key, its task is not looked at
        match_node = link_tab[0][it.key];
      end else begin
        match_node = child;
        if (task_tab[child] != '0) begin
          r.fired      = 1'b1;
          r.fired_task = task_tab[child];
          match_node   = '0;
        end
      end
    end else if (it.operation == OpTick) begin
      sum         = {1'b0, elapsed_sum} + 33'(it.elapsed);
      elapsed_sum = sum[32] ? '1 : sum[31:0];
      if (elapsed_sum > threshold) begin
        match_node  = '0;
        elapsed_sum = '0;
        r.timed_out = 1'b1;
      end
    end else if (it.operation == OpRegister && it.key < NumKeys) begin
      node  = it.seq_start ? '0 : walk_node;
      child = link_tab[node][it.key];
      if (child == '0 && used_nodes >= Capacity) begin
        // full table: nothing changes, not even the walk cursor
        r.table_full = 1'b1;
      end else begin
        if (child == '0) begin
          child                 = NodeW'(used_nodes);
          used_nodes            = used_nodes + 1;
          link_tab[node][it.key] = child;
          task_tab[child]       = '0;
        end
        if (it.seq_end) begin
          task_tab[child] = it.task_id;
          walk_node       = '0;
        end else begin
          walk_node = child;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. start stays high across back-to-back beats; it only drops
  // for a gap between bursts or a drain. A beat is taken at an edge where
  // start is high and busy is low; the prediction is made at that edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // with idle_on set, about one burst in four runs straight on with no gap
      gap = (idle_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(trie_step(it));
    if (it.operation != OpNone) sent_count++;
  endtask

  // Drop start and hold off until every expected beat is back, then idle on
  // past the last result beat; the next send starts a fresh burst.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Threshold write over APB (setup, access), then read back. Only when idle.
  task automatic write_threshold(input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ThresholdAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    threshold = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      error_count++;
      $display("%0t: threshold readback expected %h, got %h", $time, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Beat with the given operation and key; every other field random.
  function automatic item_t rand_item(input logic [1:0] op, input logic [2:0] key);
    item_t it;
    it.operation = op;
    it.key       = key;
    it.elapsed   = 16'($urandom);
    it.seq_start = 1'($urandom);
    it.seq_end   = 1'($urandom);
    it.task_id   = 8'($urandom);
    return it;
  endfunction

  // Tick sizes: weighted to zero, full scale and small steps around low thresholds.
  function automatic logic [15:0] rand_elapsed();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  // Register a fresh combination of 1..4 keys, usually from the root.
  task automatic register_combo();
    combo_t c;
    item_t  it;
    c.len = 3'($urandom_range(1, 4));
    for (int i = 0; i < 4; i++) c.keys[i] = 3'($urandom);
    for (int i = 0; i < c.len; i++) begin
      it           = rand_item(OpRegister, c.keys[i]);
      // now and then the walk continues from wherever the last one stopped
      it.seq_start = (i == 0) ? ($urandom_range(0, 7) != 0) : 1'b0;
      it.seq_end   = (i == c.len - 1);
      if (it.seq_end && $urandom_range(0, 9) == 0) it.task_id = '0;
      else if (it.seq_end && it.task_id == '0) it.task_id = 8'h01;
      send_item(it);
    end
    combos.push_back(c);
    if (combos.size() > 48) void'(combos.pop_front());
  endtask

  // Press a stored combination, sometimes after stray keys, sometimes with a tick inside.
  task automatic play_combo();
    combo_t c;
    item_t  it;
    c = combos[$urandom_range(0, combos.size() - 1)];
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) send_item(rand_item(OpPress, 3'($urandom)));
    end
    for (int i = 0; i < c.len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        it         = rand_item(OpTick, 3'($urandom));
        it.elapsed = rand_elapsed();
        send_item(it);
      end
      send_item(rand_item(OpPress, c.keys[i]));
    end
  endtask

  task automatic run_mixed_traffic(input int unsigned n_items);
    int unsigned target;
    int          pick;
    item_t       it;
    target = sent_count + n_items;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25 || combos.size() == 0) begin
        register_combo();
      end else if (pick < 65) begin
        play_combo();
      end else if (pick < 80) begin
        it         = rand_item(OpTick, 3'($urandom));
        it.elapsed = rand_elapsed();
        send_item(it);
      end else begin
        // noise: any operation, the unused one included
        send_item(rand_item(2'($urandom_range(0, 3)), 3'($urandom)));
      end
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked beats: hits, misses, clears, timeouts at the boundary, unused op.
  task automatic test_directed();
    write_threshold(32'd1000);
    send_item(item_t'{OpPress,    3'd7, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpRegister, 3'd0, 16'hFFFF, 1'b1, 1'b0, 8'h11});
    send_item(item_t'{OpRegister, 3'd7, 16'h0000, 1'b0, 1'b1, 8'hFF});
    send_item(item_t'{OpTick,     3'd0, 16'hFFFF, 1'b0, 1'b0, 8'h00});  // abandons key 7
    send_item(item_t'{OpPress,    3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpPress,    3'd7, 16'h0000, 1'b0, 1'b0, 8'h00});  // fires task FF
    send_item(item_t'{OpPress,    3'd3, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpRegister, 3'd5, 16'h0000, 1'b1, 1'b1, 8'h5A});
    // miss from node of key 3: lands on root child of key 5 without firing
    send_item(item_t'{OpPress,    3'd5, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpTick,     3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpTick,     3'd0, 16'd1000, 1'b0, 1'b0, 8'h00});  // equal: no timeout
    send_item(item_t'{OpTick,     3'd0, 16'd1,    1'b0, 1'b0, 8'h00});  // one above
    send_item(item_t'{OpPress,    3'd5, 16'h0000, 1'b0, 1'b0, 8'h00});  // fires 5A
    send_item(item_t'{OpTick,     3'd0, 16'd600,  1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpPress,    3'd2, 16'h0000, 1'b0, 1'b0, 8'h00});  // clears time
    send_item(item_t'{OpTick,     3'd0, 16'd600,  1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpRegister, 3'd5, 16'h0000, 1'b1, 1'b1, 8'h00});  // task id 0 clears
    send_item(item_t'{OpTick,     3'd0, 16'hFFFF, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpPress,    3'd5, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpNone,     3'd7, 16'hFFFF, 1'b1, 1'b1, 8'hFF});
    send_item(item_t'{OpRegister, 3'd7, 16'h0000, 1'b1, 1'b0, 8'h00});
    send_item(item_t'{OpRegister, 3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});  // walk continues
    send_item(item_t'{OpRegister, 3'd7, 16'h0000, 1'b0, 1'b1, 8'h80});
    send_item(item_t'{OpTick,     3'd0, 16'hFFFF, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpPress,    3'd7, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpPress,    3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpPress,    3'd7, 16'h0000, 1'b0, 1'b0, 8'h00});  // fires 80
  endtask

  // Random traffic under several thresholds, zero and all-ones among them.
  task automatic test_random_phases();
    write_threshold(32'd0);
    run_mixed_traffic(350);
    write_threshold(32'd40);
    run_mixed_traffic(350);
    write_threshold(32'($urandom_range(100, 200000)));
    run_mixed_traffic(350);
    write_threshold(32'hFFFF_FFFF);
    run_mixed_traffic(350);
  endtask

  // Allocate until no node is left, then hit the full table, seq_end included.
  task automatic test_table_full();
    item_t it;
    write_threshold(32'd5000);
    while (used_nodes < Capacity) begin
      it           = rand_item(OpRegister, 3'($urandom));
      it.seq_start = ($urandom_range(0, 5) == 0);
      it.seq_end   = ($urandom_range(0, 5) == 0);
      send_item(it);
    end
    repeat (40) send_item(rand_item(OpRegister, 3'($urandom)));
    run_mixed_traffic(200);
  endtask

  // A run of full-scale ticks grows the accumulator well past 16 bits under an
  // all-ones threshold; the threshold then sits at the sum and one below it.
  task automatic test_wide_accumulation();
    write_threshold(32'hFFFF_FFFF);
    idle_on = 1'b0;
    // a press clears the accumulator first
    send_item(item_t'{OpPress, 3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    repeat (40) send_item(item_t'{OpTick, 3'd0, 16'hFFFF, 1'b0, 1'b0, 8'h00});
    write_threshold(32'd2621400);  // 40 full-scale ticks: equal, no timeout
    send_item(item_t'{OpTick, 3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    write_threshold(32'd2621399);  // one below the sum: times out
    send_item(item_t'{OpTick, 3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    write_threshold(32'd0);
    idle_on = 1'b1;
    send_item(item_t'{OpTick, 3'd0, 16'h0000, 1'b0, 1'b0, 8'h00});
    send_item(item_t'{OpTick, 3'd0, 16'h0001, 1'b0, 1'b0, 8'h00});
    run_mixed_traffic(100);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done_o beat is scored against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: unexpected result beat, expected none, got %h", $time, result_o);
      end else begin
        want = pending_results.pop_front();
        check_field("fired",      8'(want.fired),      8'(result_o.fired));
        check_field("fired_task", want.fired_task,     result_o.fired_task);
        check_field("timed_out",  8'(want.timed_out),  8'(result_o.timed_out));
        check_field("table_full", 8'(want.table_full), 8'(result_o.table_full));
      end
    end
  end

  // Watchdog: cycles with no beat in either direction and no register access.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("[key_sequence_trie_matcher] ERROR");
    $finish;
  end

  initial begin
    trie_clear();
    sent_count  = 0;
    burst_left  = 0;
    idle_on     = 1'b1;
    error_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phases();
    test_table_full();
    test_wide_accumulation();

    drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[key_sequence_trie_matcher] OK");
    end else begin
      $display("[key_sequence_trie_matcher] ERROR");
    end
    $finish;
  end

endmodule

### key_sequence_trie_matcher.f
rtl/kstm_pkg.sv
rtl/kstm_node_store.sv
rtl/key_sequence_trie_matcher.sv
dv/tb_key_sequence_trie_matcher.sv
